// File: src/gjs_pkg.sv
// gjs_pkg: shared types and constants for the two-stage greedy job scheduler
// holds mode and register codes, field widths and the controller/datapath structs
// no dependencies

package gjs_pkg;

  // item kinds carried in tuser
  localparam logic [1:0] MODE_LOAD_A = 2'd0;
  localparam logic [1:0] MODE_LOAD_B = 2'd1;
  localparam logic [1:0] MODE_RUN    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_STAGE_A_MACHINES = 2'd0;
  localparam logic [1:0] REG_STAGE_B_MACHINES = 2'd1;
  localparam logic [1:0] REG_JOB_COUNT        = 2'd2;

  // field widths
  localparam int MODE_W     = 2;
  localparam int LOAD_IDX_W = 5;
  localparam int TIME_W     = 8;
  localparam int MCFG_W     = 6;
  localparam int JCFG_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int STAGE_A_W  = 18;
  localparam int TOTAL_W    = 19;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;

  // commands from controller to datapath
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;
    logic scan;
    logic update;
    logic pair;
    logic out_load;
  } gjs_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic scan_last;
    logic job_last;
    logic pair_last;
    logic jobs_zero;
  } gjs_stat_t;

endpackage

// File: src/gjs_lane.sv
// gjs_lane: one scheduling stage: time table, busy times, finish list, min scan
// depends on gjs_pkg

module gjs_lane
  import gjs_pkg::*;
#(
  parameter int MAX_MACHINES = 32,
  parameter int MAX_JOBS     = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  load_en,
  input  logic [((MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1)-1:0] load_idx,
  input  logic [TIME_W-1:0]                     load_time,
  input  logic                                  start,
  input  logic                                  rd_en,
  input  logic [((MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1)-1:0] rd_idx,
  input  logic [$clog2(MAX_MACHINES+1)-1:0]     m_lim,
  input  logic                                  update,
  input  logic [((MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1)-1:0] job_idx,
  input  logic [((MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1)-1:0] fin_rd_idx,
  output logic [$clog2(MAX_JOBS*255+1)-1:0]    best,
  output logic [$clog2(MAX_JOBS*255+1)-1:0]    fin_q
);

  localparam int MIDX_W = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int MCNT_W = $clog2(MAX_MACHINES + 1);
  localparam int BUSY_W = $clog2(MAX_JOBS * 255 + 1);

  logic [TIME_W-1:0]     time_mem [MAX_MACHINES];
  logic [BUSY_W-1:0]     busy_mem [MAX_MACHINES];
  logic [BUSY_W-1:0]     fin_mem  [MAX_JOBS];
  logic [MAX_MACHINES-1:0] busy_vld;

  logic [TIME_W-1:0]     time_q;
  logic [BUSY_W-1:0]     busy_q;
  logic                  vld_q;
  logic                  cmp_v;
  logic [MIDX_W-1:0]     cmp_j;
  logic [MIDX_W-1:0]     pick;
  logic [BUSY_W-1:0]     cand;
  logic                  in_range;

  always_ff @(posedge clk) begin
    if (load_en) begin
      time_mem[load_idx] <= load_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      time_q <= time_mem[rd_idx];
      busy_q <= busy_mem[rd_idx];
      vld_q  <= busy_vld[rd_idx];
    end
    cmp_j <= rd_idx;
  end

  always_ff @(posedge clk) begin
    if (update) begin
      busy_mem[pick]   <= best;
      fin_mem[job_idx] <= best;
    end
    fin_q <= fin_mem[fin_rd_idx];
  end

  // busy entries read as zero until written during the current run
  always_ff @(posedge clk) begin
    if (rst || start) begin
      busy_vld <= '0;
    end else if (update) begin
      busy_vld[pick] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_v <= 1'b0;
    end else begin
      cmp_v <= rd_en;
    end
  end

  assign cand     = (vld_q ? busy_q : '0) + BUSY_W'(time_q);
  assign in_range = MCNT_W'(cmp_j) < m_lim;

  // strict less-than keeps the lowest index on a tie
  always_ff @(posedge clk) begin
    if (cmp_v && in_range && (cmp_j == '0 || cand < best)) begin
      best <= cand;
      pick <= cmp_j;
    end
  end

endmodule

// File: src/gjs_dp.sv
// gjs_dp: datapath: config registers, counters, two stage lanes, pairing max, result
// depends on gjs_pkg and gjs_lane

module gjs_dp
  import gjs_pkg::*;
#(
  parameter int MAX_MACHINES = 32,
  parameter int MAX_JOBS     = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [LOAD_IDX_W-1:0] load_idx,
  input  logic [TIME_W-1:0]     load_time,
  input  gjs_cmd_t              cmd,
  output gjs_stat_t             stat,
  output logic [STAGE_A_W-1:0]  out_stage_a,
  output logic [TOTAL_W-1:0]    out_total
);

  localparam int MIDX_W = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int MCNT_W = $clog2(MAX_MACHINES + 1);
  localparam int JIDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int JCNT_W = $clog2(MAX_JOBS + 1);
  localparam int BUSY_W = $clog2(MAX_JOBS * 255 + 1);
  localparam int SUM_W  = BUSY_W + 1;

  logic [MCFG_W-1:0] cfg_a;
  logic [MCFG_W-1:0] cfg_b;
  logic [JCFG_W-1:0] cfg_n;

  logic [MCNT_W-1:0] ma_lim, mb_lim, m_max;
  logic [JCNT_W-1:0] n_lim, n_m1;
  logic [MIDX_W-1:0] sj;
  logic [JIDX_W-1:0] jc;
  logic [JIDX_W-1:0] pi;
  logic [JIDX_W-1:0] pb_idx;
  logic              idx_ok;
  logic              pair_v;
  logic [BUSY_W-1:0] best_a, best_b, fin_a, fin_b;
  logic [BUSY_W-1:0] last_a;
  logic [SUM_W-1:0]  best_sum;
  logic [SUM_W-1:0]  pair_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_a <= MCFG_W'(1);
      cfg_b <= MCFG_W'(1);
      cfg_n <= JCFG_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_STAGE_A_MACHINES: cfg_a <= cfg_wdata[MCFG_W-1:0];
        REG_STAGE_B_MACHINES: cfg_b <= cfg_wdata[MCFG_W-1:0];
        REG_JOB_COUNT:        cfg_n <= cfg_wdata[JCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // zero machines acts as one, too many saturates
  assign ma_lim = (cfg_a == '0) ? MCNT_W'(1) :
                  (int'(cfg_a) > MAX_MACHINES) ? MCNT_W'(MAX_MACHINES) : MCNT_W'(cfg_a);
  assign mb_lim = (cfg_b == '0) ? MCNT_W'(1) :
                  (int'(cfg_b) > MAX_MACHINES) ? MCNT_W'(MAX_MACHINES) : MCNT_W'(cfg_b);
  assign m_max  = (ma_lim > mb_lim) ? ma_lim : mb_lim;
  assign n_lim  = (int'(cfg_n) > MAX_JOBS) ? JCNT_W'(MAX_JOBS) : JCNT_W'(cfg_n);
  assign n_m1   = n_lim - JCNT_W'(1);
  assign pb_idx = JIDX_W'(n_m1 - JCNT_W'(pi));
  assign idx_ok = int'(load_idx) < MAX_MACHINES;

  assign stat.scan_last = MCNT_W'(sj) == (m_max - MCNT_W'(1));
  assign stat.job_last  = JCNT_W'(jc) == n_m1;
  assign stat.pair_last = JCNT_W'(pi) == n_m1;
  assign stat.jobs_zero = n_lim == '0;

  always_ff @(posedge clk) begin
    if (cmd.start || cmd.update) begin
      sj <= '0;
    end else if (cmd.scan) begin
      sj <= sj + MIDX_W'(1);
    end
    if (cmd.start) begin
      jc <= '0;
      pi <= '0;
    end else begin
      if (cmd.update) jc <= jc + JIDX_W'(1);
      if (cmd.pair)   pi <= pi + JIDX_W'(1);
    end
  end

  gjs_lane #(.MAX_MACHINES(MAX_MACHINES), .MAX_JOBS(MAX_JOBS)) u_lane_a (
    .clk        (clk),
    .rst        (rst),
    .load_en    (cmd.load_a && idx_ok),
    .load_idx   (MIDX_W'(load_idx)),
    .load_time  (load_time),
    .start      (cmd.start),
    .rd_en      (cmd.scan),
    .rd_idx     (sj),
    .m_lim      (ma_lim),
    .update     (cmd.update),
    .job_idx    (jc),
    .fin_rd_idx (pi),
    .best       (best_a),
    .fin_q      (fin_a)
  );

  gjs_lane #(.MAX_MACHINES(MAX_MACHINES), .MAX_JOBS(MAX_JOBS)) u_lane_b (
    .clk        (clk),
    .rst        (rst),
    .load_en    (cmd.load_b && idx_ok),
    .load_idx   (MIDX_W'(load_idx)),
    .load_time  (load_time),
    .start      (cmd.start),
    .rd_en      (cmd.scan),
    .rd_idx     (sj),
    .m_lim      (mb_lim),
    .update     (cmd.update),
    .job_idx    (jc),
    .fin_rd_idx (pb_idx),
    .best       (best_b),
    .fin_q      (fin_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_v <= 1'b0;
    end else begin
      pair_v <= cmd.pair;
    end
  end

  assign pair_sum = SUM_W'(fin_a) + SUM_W'(fin_b);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best_sum <= '0;
      last_a   <= '0;
    end else begin
      if (pair_v && pair_sum > best_sum) best_sum <= pair_sum;
      if (cmd.update) last_a <= best_a;
    end
    if (cmd.out_load) begin
      out_stage_a <= STAGE_A_W'(last_a);
      out_total   <= TOTAL_W'(best_sum);
    end
  end

endmodule

// File: src/gjs_ctrl.sv
// gjs_ctrl: controller state machine for loads, scans, pairing pass and result handoff
// depends on gjs_pkg

module gjs_ctrl
  import gjs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MODE_W-1:0] in_mode,
  output logic              out_valid,
  input  logic              out_ready,
  output gjs_cmd_t          cmd,
  input  gjs_stat_t         stat
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SDRAIN,
    ST_UPDATE,
    ST_PAIR,
    ST_PDRAIN,
    ST_EMIT
  } state_t;

  state_t state;

  assign in_ready = state == ST_IDLE;

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_mode)
            MODE_LOAD_A: cmd.load_a = 1'b1;
            MODE_LOAD_B: cmd.load_b = 1'b1;
            MODE_RUN:    cmd.start  = 1'b1;
            default: ;
          endcase
        end
      end
      ST_SCAN:   cmd.scan     = 1'b1;
      ST_SDRAIN: ;
      ST_UPDATE: cmd.update   = 1'b1;
      ST_PAIR:   cmd.pair     = 1'b1;
      ST_PDRAIN: ;
      ST_EMIT:   cmd.out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !cmd.out_load) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (cmd.start) state <= stat.jobs_zero ? ST_EMIT : ST_SCAN;
        end
        ST_SCAN: begin
          if (stat.scan_last) state <= ST_SDRAIN;
        end
        ST_SDRAIN: state <= ST_UPDATE;
        ST_UPDATE: state <= stat.job_last ? ST_PAIR : ST_SCAN;
        ST_PAIR: begin
          if (stat.pair_last) state <= ST_PDRAIN;
        end
        ST_PDRAIN: state <= ST_EMIT;
        ST_EMIT: begin
          if (cmd.out_load) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_a, cmd.load_b, cmd.start, cmd.scan, cmd.update, cmd.pair, cmd.out_load}))
    else $error("more than one datapath command at once");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register loaded while a result is pending");

  a_update_next: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> (state == ST_SCAN || state == ST_PAIR))
    else $error("job update not followed by next scan or pairing pass");

  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> (out_valid && state == ST_IDLE))
    else $error("result load did not raise tvalid and return to idle");

endmodule

// File: src/two_stage_greedy_job_scheduler_core.sv
// two_stage_greedy_job_scheduler_core: top level, ties controller and datapath to ports
// load items (stage A/B times) are accepted back to back, one per cycle
// run item: with n jobs and M = max of the two machine counts, the result shows on m_axis
//   after an M-machine scan per job at one machine per cycle, then a pairing pass at one job
//   per cycle (neither for zero jobs); no item is taken during a run
// reset: one machine per stage, one job; tables undefined until written, busy cleared per run

module two_stage_greedy_job_scheduler_core
  import gjs_pkg::*;
#(
  parameter int MAX_MACHINES = 32,
  parameter int MAX_JOBS     = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // machine_index[4:0], machine_time[12:5], zero pad
  input  logic [MODE_W-1:0]     s_axis_tuser,   // mode[1:0]
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // stage_a_finish[17:0], total_finish[36:18], zero pad
  // configuration writes
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  gjs_cmd_t             cmd;
  gjs_stat_t            stat;
  logic [STAGE_A_W-1:0] out_stage_a;
  logic [TOTAL_W-1:0]   out_total;

  // sequencing: loads, per-job scan, busy update, pairing pass, result handoff
  gjs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_mode   (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // both stages are scheduled side by side, each lane skips machines past its own count
  gjs_dp #(.MAX_MACHINES(MAX_MACHINES), .MAX_JOBS(MAX_JOBS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .load_idx    (s_axis_tdata[LOAD_IDX_W-1:0]),
    .load_time   (s_axis_tdata[LOAD_IDX_W +: TIME_W]),
    .cmd         (cmd),
    .stat        (stat),
    .out_stage_a (out_stage_a),
    .out_total   (out_total)
  );

  // result register contents, held until the transaction completes
  assign m_axis_tdata = {(OUT_DATA_W - STAGE_A_W - TOTAL_W)'(0), out_total, out_stage_a};

endmodule
